// ----- design/multi_timer_table_with_pending_arbiter_core_defines.svh -----
// Assertion macros used by the timer table control module.
`ifndef MULTI_TIMER_TABLE_WITH_PENDING_ARBITER_CORE_DEFINES_SVH
`define MULTI_TIMER_TABLE_WITH_PENDING_ARBITER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MTT_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MTT_ASSERT_NEVER(lbl, expr, msg)
`define MTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- design/mtt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mtt_pkg;
    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W = $clog2(TIMER_SLOTS);
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
    localparam logic [15:0] MIN_TIMEOUT_RESET = 16'd50;
    localparam int ID_SHIFT = 16;

    localparam logic [2:0] KIND_SET      = 3'd0;
    localparam logic [2:0] KIND_KILL_ONE = 3'd1;
    localparam logic [2:0] KIND_TICK     = 3'd2;
    localparam logic [2:0] KIND_FETCH    = 3'd3;
    localparam logic [2:0] KIND_KILL_ALL = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] owner;
        logic [31:0] event_id;
        logic [31:0] period;
        logic        system_flag;
        logic [15:0] elapsed;
    } t_item;

    typedef struct packed {
        logic        ok;
        logic [31:0] timer_id;
        logic [15:0] owner_out;
        logic        system_out;
        logic [31:0] next_timeout;
        logic        any_pending;
    } t_result;

    typedef struct packed {
        logic [15:0] owner;
        logic [31:0] event_id;
        logic [31:0] period;
        logic [31:0] remaining;
    } t_slot;

    localparam int SLOT_DW = $bits(t_slot);

    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
    } t_sts;
endpackage
`default_nettype wire

// ----- design/mtt_intf.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface mtt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] owner;
    logic [31:0] event_id;
    logic [31:0] period;
    logic        system_flag;
    logic [15:0] elapsed;
    modport source (output valid, kind, owner, event_id, period, system_flag, elapsed,
                    input ready);
    modport sink (input valid, kind, owner, event_id, period, system_flag, elapsed,
                  output ready);
endinterface

interface mtt_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] timer_id;
    logic [15:0] owner_out;
    logic        system_out;
    logic [31:0] next_timeout;
    logic        any_pending;
    modport source (output valid, ok, timer_id, owner_out, system_out, next_timeout,
                    any_pending, input ready);
    modport sink (input valid, ok, timer_id, owner_out, system_out, next_timeout,
                  any_pending, output ready);
endinterface
`default_nettype wire

// ----- design/mtt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ----- design/mtt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "multi_timer_table_with_pending_arbiter_core_defines.svh"
module mtt_ctrl
    import mtt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `MTT_ASSERT_NEVER(a_no_overlap, o_in_ready && o_out_valid, "request taken while busy")
    `MTT_ASSERT_NEXT(a_scan_exit, (r_state == S_SCAN) && i_sts.scan_done,
                     r_state == S_COMMIT, "scan did not end")
    `MTT_ASSERT_NEXT(a_commit_once, r_state == S_COMMIT, r_state == S_RESP, "commit lasted too long")
endmodule
`default_nettype wire

// ----- design/mtt_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mtt_dpath
    import mtt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire t_item       i_item,
    input  wire logic [15:0] i_min_timeout,
    output t_result          o_res
);
    t_item                   r_item;
    logic [TIMER_SLOTS-1:0]  r_used, r_sys, r_pend;
    logic [SLOT_W-1:0]       r_scan_start;
    logic [CNT_W-1:0]        r_cnt;
    logic [SLOT_W-1:0]       r_addr, r_pidx, r_hit, r_free;
    logic                    r_pv, r_found, r_free_found;
    logic [31:0]             r_least;
    logic [31:0]             r_f_ev;
    logic [15:0]             r_f_owner;
    logic                    r_f_sys;
    logic                    r_ok, r_sys_out;
    logic [31:0]             r_tid, r_next;
    logic [15:0]             r_owner_out;

    logic [SLOT_DW-1:0] ram_rdata, ram_wdata;
    logic               ram_we, ram_re;
    logic [SLOT_W-1:0]  ram_waddr;
    t_slot              rd, wr;

    logic        owner_hit, ev_hit, p_used, expired;
    logic [31:0] tick_rem, sat_rem, new_id;
    logic [32:0] sum;
    logic        set_bad, set_upd, set_new;
    logic [SLOT_W-1:0] target;

    assign rd        = t_slot'(ram_rdata);
    assign owner_hit = rd.owner == r_item.owner;
    assign ev_hit    = rd.event_id == r_item.event_id;
    assign p_used    = r_used[r_pidx];
    assign expired   = rd.remaining <= {16'd0, r_item.elapsed};
    assign tick_rem  = expired ? rd.period : rd.remaining - {16'd0, r_item.elapsed};
    assign sum       = {1'b0, r_item.period} + {17'd0, r_item.elapsed};
    assign sat_rem   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

    assign set_bad = (r_item.owner != '0) && (r_item.event_id == '0);
    assign set_upd = !set_bad && r_found;
    assign set_new = !set_bad && !r_found && r_free_found;
    assign target  = set_upd ? r_hit : r_free;
    assign new_id  = (r_item.owner != '0) ? r_item.event_id
                   : 32'((32'(r_free) + 32'd1) << ID_SHIFT);

    assign ram_re = i_cmd.scan && (r_cnt != CNT_W'(TIMER_SLOTS));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pidx;
        wr        = '{owner: rd.owner, event_id: rd.event_id, period: rd.period,
                      remaining: tick_rem};
        if (i_cmd.commit) begin
            ram_waddr = target;
            ram_we    = (r_item.kind == KIND_SET) && (set_upd || set_new);
            wr        = '{owner: r_item.owner, event_id: set_upd ? r_item.event_id : new_id,
                          period: r_item.period, remaining: sat_rem};
        end else if (i_cmd.scan && r_pv && (r_item.kind == KIND_TICK) && p_used) begin
            ram_we = 1'b1;
        end
    end
    assign ram_wdata = SLOT_DW'(wr);

    mtt_ram #(.WIDTH(SLOT_DW), .DEPTH(TIMER_SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.scan_done = (r_cnt == CNT_W'(TIMER_SLOTS)) && !r_pv;

    // Slot state lives in flops; the payload words are read one slot a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_sys        <= '0;
            r_pend       <= '0;
            r_scan_start <= '0;
            r_cnt        <= '0;
            r_addr       <= '0;
            r_pv         <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_item       <= i_item;
                r_cnt        <= '0;
                r_addr       <= (i_item.kind == KIND_FETCH) ? r_scan_start : '0;
                r_pv         <= 1'b0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
                r_least      <= 32'hFFFF_FFFF;
            end
            if (i_cmd.scan) begin
                r_pv <= ram_re;
                if (ram_re) begin
                    r_cnt  <= r_cnt + 1'b1;
                    r_pidx <= r_addr;
                    r_addr <= (r_addr == SLOT_W'(TIMER_SLOTS - 1)) ? '0 : r_addr + 1'b1;
                end
                if (r_pv) begin
                    case (r_item.kind)
                        KIND_SET: begin
                            if (p_used && (r_item.owner != '0) && owner_hit && ev_hit
                                    && !r_found) begin
                                r_found <= 1'b1;
                                r_hit   <= r_pidx;
                            end
                            if (!p_used && !r_free_found) begin
                                r_free_found <= 1'b1;
                                r_free       <= r_pidx;
                            end
                        end
                        KIND_KILL_ONE: begin
                            if (p_used && owner_hit && ev_hit && !r_found) begin
                                r_found        <= 1'b1;
                                r_used[r_pidx] <= 1'b0;
                                r_pend[r_pidx] <= 1'b0;
                                r_sys[r_pidx]  <= 1'b0;
                            end
                        end
                        KIND_KILL_ALL: begin
                            if (p_used && (r_item.owner != '0) && owner_hit) begin
                                r_found        <= 1'b1;
                                r_used[r_pidx] <= 1'b0;
                                r_pend[r_pidx] <= 1'b0;
                                r_sys[r_pidx]  <= 1'b0;
                            end
                        end
                        KIND_TICK: begin
                            if (p_used) begin
                                if (expired) begin
                                    r_pend[r_pidx] <= 1'b1;
                                end
                                if (tick_rem < r_least) begin
                                    r_least <= tick_rem;
                                end
                            end
                        end
                        KIND_FETCH: begin
                            if (p_used && r_pend[r_pidx] && !r_found) begin
                                r_found        <= 1'b1;
                                r_hit          <= r_pidx;
                                r_pend[r_pidx] <= 1'b0;
                                r_f_ev         <= rd.event_id;
                                r_f_owner      <= rd.owner;
                                r_f_sys        <= r_sys[r_pidx];
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (i_cmd.commit) begin
                r_ok        <= 1'b0;
                r_tid       <= '0;
                r_owner_out <= '0;
                r_sys_out   <= 1'b0;
                r_next      <= '0;
                case (r_item.kind) inside
                    KIND_SET: begin
                        if (set_upd || set_new) begin
                            r_ok           <= 1'b1;
                            r_tid          <= set_upd ? r_item.event_id : new_id;
                            r_sys[target]  <= r_item.system_flag;
                            r_used[target] <= 1'b1;
                            if (r_item.period == '0) begin
                                r_pend[target] <= 1'b1;
                            end else if (set_new) begin
                                r_pend[target] <= 1'b0;
                            end
                        end
                    end
                    KIND_KILL_ONE, KIND_KILL_ALL: r_ok <= r_found;
                    KIND_TICK: begin
                        r_ok   <= 1'b1;
                        r_next <= (r_least < {16'd0, i_min_timeout}) ?
                                  {16'd0, i_min_timeout} : r_least;
                    end
                    KIND_FETCH: begin
                        if (r_found) begin
                            r_ok         <= 1'b1;
                            r_tid        <= r_f_ev;
                            r_owner_out  <= r_f_owner;
                            r_sys_out    <= r_f_sys;
                            r_scan_start <= (r_hit == SLOT_W'(TIMER_SLOTS - 1)) ?
                                            '0 : r_hit + 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_res = '{ok: r_ok, timer_id: r_tid, owner_out: r_owner_out,
                     system_out: r_sys_out, next_timeout: r_next,
                     any_pending: |(r_used & r_pend)};
endmodule
`default_nettype wire

// ----- design/multi_timer_table_with_pending_arbiter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Periodic timer table with a round-robin pick of pending timers.
// Requests arrive on i_req (valid/ready) and carry a kind: set, kill one,
// tick, fetch pending or kill all of an owner. Each request yields exactly
// one response on o_rsp.
// The block works on one request at a time. Every request walks all
// TIMER_SLOTS slots of the slot RAM, one slot per cycle through its single
// read port, and i_req.ready is high only while the block is idle.
// The response stays on o_rsp until it is taken; a stalled receiver holds
// the block and no new request is accepted meanwhile.
// The user writes the next-timeout floor at APB address 0, only while
// the block is idle; the block itself does not enforce this.
// Synchronous reset empties the table, sets the fetch pointer to slot 0 and
// the timeout floor to 50; no clearing pass is needed, since slot RAM
// contents are used only for slots whose used flag is set.
module multi_timer_table_with_pending_arbiter_core
    import mtt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mtt_req_if.sink          i_req,
    mtt_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    logic [15:0] r_min_timeout;
    t_cmd        cmd;
    t_sts        sts;
    t_item       item;
    t_result     res;
    logic        in_ready, out_valid;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, r_min_timeout} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_timeout <= MIN_TIMEOUT_RESET;
        end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
            r_min_timeout <= pwdata[15:0];
        end
    end

    assign item = '{kind: i_req.kind, owner: i_req.owner, event_id: i_req.event_id,
                    period: i_req.period, system_flag: i_req.system_flag,
                    elapsed: i_req.elapsed};

    mtt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    mtt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_item        (item),
        .i_min_timeout (r_min_timeout),
        .o_res         (res)
    );

    assign i_req.ready        = in_ready;
    assign o_rsp.valid        = out_valid;
    assign o_rsp.ok           = res.ok;
    assign o_rsp.timer_id     = res.timer_id;
    assign o_rsp.owner_out    = res.owner_out;
    assign o_rsp.system_out   = res.system_out;
    assign o_rsp.next_timeout = res.next_timeout;
    assign o_rsp.any_pending  = res.any_pending;
endmodule
`default_nettype wire

// ----- verif/tb_multi_timer_table_with_pending_arbiter_core.sv -----
`timescale 1ns / 1ps
module tb_multi_timer_table_with_pending_arbiter_core;
    import mtt_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1668;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    mtt_req_if req_bus ();
    mtt_rsp_if rsp_bus ();

    multi_timer_table_with_pending_arbiter_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_bus.sink), .o_rsp(rsp_bus.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the timer table.
    logic [15:0] floor_ms;
    logic        sh_used [TIMER_SLOTS];
    logic        sh_sys [TIMER_SLOTS];
    logic        sh_pend [TIMER_SLOTS];
    logic [15:0] sh_owner [TIMER_SLOTS];
    logic [31:0] sh_event [TIMER_SLOTS];
    logic [31:0] sh_period [TIMER_SLOTS];
    logic [31:0] sh_remain [TIMER_SLOTS];
    int          fetch_ptr;

    t_result pending_responses[$];
    int      failures = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      idle_cycles = 0;

    function automatic logic [31:0] add_saturate(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic table_reset();
        floor_ms = MIN_TIMEOUT_RESET;
        fetch_ptr = 0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            sh_used[i] = 0; sh_sys[i] = 0; sh_pend[i] = 0;
            sh_owner[i] = 0; sh_event[i] = 0; sh_period[i] = 0; sh_remain[i] = 0;
        end
    endtask

    function automatic void load_timer(int i, t_item it);
        sh_period[i] = it.period;
        sh_remain[i] = add_saturate(it.period, {16'd0, it.elapsed});
        sh_sys[i] = it.system_flag;
        if (it.period == 0) sh_pend[i] = 1;
    endfunction

    function automatic t_result timer_table_step(t_item it);
        t_result r;
        bit done;
        int i;
        int s;
        logic [31:0] least;
        r = '0;
        case (it.kind)
            KIND_SET: begin
                done = 0;
                if (it.owner != 0 && it.event_id == 0) begin
                    done = 1;
                end else if (it.owner != 0) begin
                    for (i = 0; i < TIMER_SLOTS && !done; i++) begin
                        if (sh_used[i] && sh_owner[i] == it.owner
                                && sh_event[i] == it.event_id) begin
                            load_timer(i, it);
                            r.ok = 1; r.timer_id = it.event_id; done = 1;
                        end
                    end
                end
                if (!done) begin
                    for (i = 0; i < TIMER_SLOTS; i++) if (!sh_used[i]) break;
                    if (i < TIMER_SLOTS) begin
                        sh_used[i] = 1; sh_pend[i] = 0; sh_owner[i] = it.owner;
                        sh_event[i] = (it.owner != 0) ? it.event_id : (32'(i + 1) << ID_SHIFT);
                        load_timer(i, it);
                        r.ok = 1; r.timer_id = sh_event[i];
                    end
                end
            end
            KIND_KILL_ONE: begin
                for (i = 0; i < TIMER_SLOTS; i++) begin
                    if (sh_used[i] && sh_owner[i] == it.owner && sh_event[i] == it.event_id) begin
                        sh_used[i] = 0; sh_pend[i] = 0; sh_sys[i] = 0;
                        sh_owner[i] = 0; sh_event[i] = 0; r.ok = 1;
                        break;
                    end
                end
            end
            KIND_TICK: begin
                least = 32'hFFFF_FFFF;
                for (i = 0; i < TIMER_SLOTS; i++) begin
                    if (sh_used[i]) begin
                        if (sh_remain[i] <= {16'd0, it.elapsed}) begin
                            sh_pend[i] = 1; sh_remain[i] = sh_period[i];
                        end else begin
                            sh_remain[i] = sh_remain[i] - it.elapsed;
                        end
                        if (sh_remain[i] < least) least = sh_remain[i];
                    end
                end
                if (least < {16'd0, floor_ms}) least = {16'd0, floor_ms};
                r.next_timeout = least; r.ok = 1;
            end
            KIND_FETCH: begin
                for (i = 0; i < TIMER_SLOTS; i++) begin
                    s = (fetch_ptr + i) % TIMER_SLOTS;
                    if (sh_used[s] && sh_pend[s]) begin
                        sh_pend[s] = 0; r.ok = 1; r.timer_id = sh_event[s];
                        r.owner_out = sh_owner[s]; r.system_out = sh_sys[s];
                        fetch_ptr = (s + 1) % TIMER_SLOTS;
                        break;
                    end
                end
            end
            KIND_KILL_ALL: begin
                if (it.owner != 0) begin
                    for (i = 0; i < TIMER_SLOTS; i++) begin
                        if (sh_used[i] && sh_owner[i] == it.owner) begin
                            sh_used[i] = 0; sh_pend[i] = 0; sh_sys[i] = 0;
                            sh_owner[i] = 0; sh_event[i] = 0; r.ok = 1;
                        end
                    end
                end
            end
            default: ;
        endcase
        for (i = 0; i < TIMER_SLOTS; i++) if (sh_used[i] && sh_pend[i]) r.any_pending = 1;
        return r;
    endfunction

    // Response checker and receiver stalls.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                got = '{rsp_bus.ok, rsp_bus.timer_id, rsp_bus.owner_out, rsp_bus.system_out,
                        rsp_bus.next_timeout, rsp_bus.any_pending};
                if (pending_responses.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, got);
                    failures++;
                end else begin
                    want = pending_responses.pop_front();
                    if (got.ok !== want.ok || got.timer_id !== want.timer_id
                            || got.owner_out !== want.owner_out
                            || got.system_out !== want.system_out
                            || got.next_timeout !== want.next_timeout
                            || got.any_pending !== want.any_pending) begin
                        $display("%0t: mismatch expected %h actual %h", $time, want, got);
                        failures++;
                    end
                end
            end
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any accepted request, response or APB access.
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** multi_timer_table_with_pending_arbiter_core: FAILED **");
            $finish;
        end
    end

    task automatic send_request(t_item it, bit check_fixed, t_result fixed);
        t_result r;
        while ($urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind <= it.kind; req_bus.owner <= it.owner;
        req_bus.event_id <= it.event_id; req_bus.period <= it.period;
        req_bus.system_flag <= it.system_flag; req_bus.elapsed <= it.elapsed;
        do @(posedge i_clk); while (!req_bus.ready);
        r = timer_table_step(it);
        if (check_fixed && r !== fixed) begin
            $display("%0t: directed row expected %h predicted %h", $time, fixed, r);
            failures++;
        end
        pending_responses.push_back(r);
    endtask

    task automatic write_floor(logic [15:0] value);
        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        floor_ms = value;
        @(posedge i_clk);
        if (prdata[15:0] !== value) begin
            $display("%0t: floor readback expected %h actual %h", $time, value, prdata[15:0]);
            failures++;
        end
    endtask

    function automatic t_item random_request();
        t_item it;
        int sel;
        it.owner = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
        if ($urandom_range(15) == 0) it.owner = 16'($urandom);
        it.event_id = 32'($urandom_range(1, 6));
        if ($urandom_range(15) == 0) it.event_id = $urandom;
        if ($urandom_range(31) == 0) it.event_id = 0;
        it.period = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(1, 300));
        if ($urandom_range(15) == 0) it.period = $urandom;
        it.system_flag = 1'($urandom);
        it.elapsed = 16'($urandom_range(0, 200));
        if ($urandom_range(15) == 0) it.elapsed = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 35) it.kind = KIND_SET;
        else if (sel < 50) it.kind = KIND_KILL_ONE;
        else if (sel < 70) it.kind = KIND_TICK;
        else if (sel < 92) it.kind = KIND_FETCH;
        else if (sel < 97) it.kind = KIND_KILL_ALL;
        else it.kind = 3'($urandom_range(5, 7));
        // Ownerless kills should hit generated ids most of the time.
        if (it.kind == KIND_KILL_ONE && it.owner == 0 && $urandom_range(3) != 0)
            it.event_id = 32'($urandom_range(1, TIMER_SLOTS)) << ID_SHIFT;
        return it;
    endfunction

    typedef struct {
        t_item   it;
        bit      fixed;
        t_result want;
    } t_row;

    t_row directed_rows[$];

    initial begin
        t_item it;
        t_result r0;
        int phase_pct[4][2];
        phase_pct = '{'{0, 0}, '{50, 0}, '{0, 50}, '{32, 32}};
        req_bus.valid = 1'b0; req_bus.kind = '0; req_bus.owner = '0;
        req_bus.event_id = '0; req_bus.period = '0; req_bus.system_flag = 1'b0;
        req_bus.elapsed = '0;
        table_reset();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        r0 = '0;
        // Empty table: tick reports all ones; fetch, kill all, a set with event id 0 and an unknown kind fail.
        directed_rows.push_back('{'{KIND_TICK, 16'd0, 32'd0, 32'd0, 1'b0, 16'hFFFF}, 1,
                                  '{1'b1, 32'd0, 16'd0, 1'b0, 32'hFFFF_FFFF, 1'b0}});
        directed_rows.push_back('{'{KIND_FETCH, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0}, 1, r0});
        directed_rows.push_back('{'{KIND_KILL_ALL, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0}, 1, r0});
        directed_rows.push_back('{'{KIND_SET, 16'd7, 32'd0, 32'd5, 1'b0, 16'd0}, 1, r0});
        directed_rows.push_back('{'{3'd7, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                    16'hFFFF}, 1, r0});
        // Ownerless set in slot 0 gets id 1<<16.
        directed_rows.push_back('{'{KIND_SET, 16'd0, 32'd0, 32'd100, 1'b1, 16'd0}, 1,
                                  '{1'b1, 32'h0001_0000, 16'd0, 1'b0, 32'd0, 1'b0}});
        directed_rows.push_back('{'{KIND_SET, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                                    16'hFFFF}, 0, r0});
        directed_rows.push_back('{'{KIND_SET, 16'd3, 32'd9, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_SET, 16'd3, 32'd9, 32'd40, 1'b1, 16'd5}, 0, r0});
        directed_rows.push_back('{'{KIND_TICK, 16'd0, 32'd0, 32'd0, 1'b0, 16'd45}, 0, r0});
        directed_rows.push_back('{'{KIND_FETCH, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_FETCH, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_TICK, 16'd0, 32'd0, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_KILL_ONE, 16'd0, 32'h0001_0000, 32'd0, 1'b0, 16'd0},
                                  0, r0});
        directed_rows.push_back('{'{KIND_KILL_ONE, 16'd3, 32'd8, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_KILL_ALL, 16'd3, 32'd0, 32'd0, 1'b0, 16'd0}, 0, r0});
        directed_rows.push_back('{'{KIND_KILL_ALL, 16'hFFFF, 32'd0, 32'd0, 1'b0, 16'd0},
                                  0, r0});
        foreach (directed_rows[k]) send_request(directed_rows[k].it, directed_rows[k].fixed,
                                                directed_rows[k].want);
        // Fill the table to its limit so a set finds no free slot.
        for (int k = 0; k <= TIMER_SLOTS; k++) begin
            it = '{KIND_SET, 16'd0, 32'd0, 32'(k * 10), 1'($urandom), 16'd0};
            send_request(it, 0, r0);
        end
        send_request('{KIND_TICK, 16'd0, 32'd0, 32'd0, 1'b0, 16'd1}, 0, r0);
        for (int k = 1; k <= TIMER_SLOTS; k++)
            send_request('{KIND_KILL_ONE, 16'd0, 32'(k) << ID_SHIFT, 32'd0, 1'b0, 16'd0}, 0, r0);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_floor(16'd0);
                1: write_floor(16'hFFFF);
                2: write_floor(16'd20);
                3: write_floor(MIN_TIMEOUT_RESET);
                default: write_floor(16'($urandom_range(0, 150)));
            endcase
            send_idle_pct = phase_pct[p % 4][0];
            recv_stall_pct = phase_pct[p % 4][1];
            for (int k = 0; k < N_RANDOM / 6; k++) begin
                it = random_request();
                send_request(it, 0, r0);
            end
        end

        req_bus.valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (failures == 0)
            $display("** multi_timer_table_with_pending_arbiter_core: PASSED **");
        else
            $display("** multi_timer_table_with_pending_arbiter_core: FAILED **");
        $finish;
    end
endmodule
